@@ rtl/core/rrn_pkg.sv @@
// Shared types, widths and constants for the RMS row normalizer.
package rrn_pkg;

    localparam int ROW_LEN_DEF = 64;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int CNT_W       = 7;
    localparam int SQ_W        = 31;
    localparam int SUM_W       = 37;
    localparam int EPS_W       = 32;
    localparam int PROD_W      = 32;
    localparam int DIV_N       = 38;
    localparam int DIV_D       = 20;
    localparam int DIV_CNT_W   = 6;
    localparam int RAD_W       = 38;
    localparam int ROOT_W      = 19;
    localparam int SQRT_CNT_W  = 5;

    localparam logic [EPS_W-1:0] EPS_RESET = 32'd17;
    localparam logic [15:0]      Y_MAX     = 16'h7FFF;
    localparam logic [15:0]      Y_MIN     = 16'h8000;

    typedef struct packed {
        logic signed [15:0] x_value;
        logic signed [15:0] weight_value;
        logic               row_end;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] y_value;
        logic               saturated;
        logic               row_last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ACCUM,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_ROOT_GO,
        ST_ROOT_WAIT,
        ST_READ,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_EMIT
    } t_state;

endpackage

@@ rtl/core/rms_row_normalizer.sv @@
// Top level of the RMS row normalizer: sequencer, row stores and output register.
//
// Usage: each input transaction on (i_valid, o_stall, i_in) carries one row element
// and its weight. The row closes on row_end or when ROW_LEN elements, or STORE_DEPTH if
// that is fewer, have arrived. Collecting an element passes through the square and
// accumulate states; o_stall is high while one is processed. At close, the
// divider takes the mean of squares and the square-root unit the root, each with
// its start and wait states. Then every element is read back, multiplied by its
// weight and divided by the root in the same divider, one bit per cycle. No input is
// taken until the last result of the row has been loaded into the output register.
// Results leave on (o_valid, i_stall, o_out), one output transaction per element.
// A stalled result holds in the output register; the sequencer waits for it to be
// taken before loading the next one. Epsilon is written via i_cfg_we/i_cfg_data;
// the user must do so only while the block is idle; the block does not enforce it.
// Reset (synchronous, active low) returns to idle, clears the running sum and count,
// empties the output register and sets epsilon to 17. The stores need no clearing.
module rms_row_normalizer #(
    parameter int ROW_LEN = rrn_pkg::ROW_LEN_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  rrn_pkg::t_in_item         i_in,
    output logic                      o_valid,
    input  logic                      i_stall,
    output rrn_pkg::t_out_item        o_out,
    input  logic                      i_cfg_we,
    input  logic [rrn_pkg::EPS_W-1:0] i_cfg_data
);
    import rrn_pkg::*;

    t_state r_state;
    t_state n_state;

    logic [15:0] mem_x [STORE_DEPTH];
    logic [15:0] mem_w [STORE_DEPTH];

    logic [EPS_W-1:0]         r_eps;
    logic [CNT_W-1:0]         r_count;
    logic [SUM_W-1:0]         r_sum;
    logic signed [15:0]       r_x_in;
    logic                     r_close;
    logic [SQ_W-1:0]          r_sq;
    logic [ADDR_W-1:0]        r_idx;
    logic signed [15:0]       r_rd_x;
    logic signed [15:0]       r_rd_w;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_neg;
    logic [ROOT_W-1:0]        r_rms;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic                     accept;
    logic [CNT_W-1:0]         count_inc;
    logic                     close;
    logic signed [PROD_W-1:0] sq_full;
    logic signed [PROD_W-1:0] prod_full;
    logic [PROD_W-1:0]        mag;
    logic                     div_start;
    logic                     div_busy;
    logic [DIV_N-1:0]         div_dvd;
    logic [DIV_D-1:0]         div_dvs;
    logic [DIV_N-1:0]         div_quot;
    logic                     sqrt_start;
    logic                     sqrt_busy;
    logic [RAD_W-1:0]         radicand;
    logic [ROOT_W-1:0]        root;
    logic                     out_free;
    logic                     last_elem;
    t_out_item                res;

    assign accept    = i_valid && (r_state == ST_IDLE);
    assign count_inc = r_count + 1'b1;
    assign close     = i_in.row_end || (count_inc >= CNT_W'(ROW_LEN)) ||
                       (count_inc >= CNT_W'(STORE_DEPTH));
    assign sq_full   = r_x_in * r_x_in;
    assign prod_full = r_rd_x * r_rd_w;
    assign mag       = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
    assign out_free  = !r_out_valid || !i_stall;
    assign last_elem = (CNT_W'(r_idx) + 1'b1) == r_count;

    // One divider serves both the mean of squares and every output element.
    assign div_dvd  = (r_state == ST_MEAN_GO) ? DIV_N'(r_sum) : DIV_N'(mag);
    assign div_dvs  = (r_state == ST_MEAN_GO) ? DIV_D'(r_count) : DIV_D'(r_rms);
    assign radicand = RAD_W'(div_quot + RAD_W'(r_eps));

    rrn_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    rrn_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (radicand),
        .o_busy     (sqrt_busy),
        .o_root     (root)
    );

    // Clamp the quotient magnitude and restore the sign.
    always_comb begin
        res.row_last = last_elem;
        if (r_neg) begin
            if (div_quot > DIV_N'(32768)) begin
                res.y_value   = Y_MIN;
                res.saturated = 1'b1;
            end else begin
                res.y_value   = 16'(16'd0 - div_quot[15:0]);
                res.saturated = 1'b0;
            end
        end else begin
            if (div_quot > DIV_N'(32767)) begin
                res.y_value   = Y_MAX;
                res.saturated = 1'b1;
            end else begin
                res.y_value   = div_quot[15:0];
                res.saturated = 1'b0;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                n_state = ST_ACCUM;
            end
            ST_ACCUM: begin
                n_state = r_close ? ST_MEAN_GO : ST_IDLE;
            end
            ST_MEAN_GO: begin
                div_start = 1'b1;
                n_state   = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT: begin
                if (!div_busy) begin
                    n_state = ST_ROOT_GO;
                end
            end
            ST_ROOT_GO: begin
                sqrt_start = 1'b1;
                n_state    = ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT: begin
                if (!sqrt_busy) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                div_start = 1'b1;
                n_state   = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (!div_busy) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = last_elem ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Row stores, written on accept and read with a registered port.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            mem_x[r_count[ADDR_W-1:0]] <= i_in.x_value;
            mem_w[r_count[ADDR_W-1:0]] <= i_in.weight_value;
        end
        r_rd_x <= mem_x[r_idx];
        r_rd_w <= mem_w[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_RESET;
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_idx   <= '0;
        end else begin
            if (accept) begin
                r_count <= count_inc;
            end
            if (r_state == ST_ACCUM) begin
                r_sum <= r_sum + SUM_W'(r_sq);
            end
            if (r_state == ST_EMIT && out_free) begin
                if (last_elem) begin
                    r_count <= '0;
                    r_sum   <= '0;
                    r_idx   <= '0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x_in  <= i_in.x_value;
            r_close <= close;
        end
        if (r_state == ST_SQUARE) begin
            r_sq <= sq_full[SQ_W-1:0];
        end
        if (r_state == ST_MUL) begin
            r_prod <= prod_full;
        end
        if (r_state == ST_DIV_GO) begin
            r_neg <= r_prod[PROD_W-1];
        end
        if (r_state == ST_ROOT_WAIT && !sqrt_busy) begin
            // A zero root can only come from a zero epsilon; it is taken as one.
            r_rms <= (root == '0) ? ROOT_W'(1) : root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && out_free) begin
            r_out <= res;
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    a_rise_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(o_valid)) |-> $past(r_state) == ST_EMIT)
        else $error("output valid rose without a result being loaded");

    a_row_done_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(r_state) == ST_EMIT && r_state == ST_IDLE)
        |-> (r_count == '0 && r_sum == '0 && o_out.row_last))
        else $error("row finished without clearing the accumulators");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STORE_DEPTH))
        else $error("element count exceeds store depth");

    a_idle_units_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_state == ST_IDLE) |-> (!div_busy && !sqrt_busy))
        else $error("arithmetic unit busy while idle");

endmodule

@@ rtl/core/rrn_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module rrn_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rrn_pkg::DIV_N-1:0]  i_dividend,
    input  logic [rrn_pkg::DIV_D-1:0]  i_divisor,
    output logic                       o_busy,
    output logic [rrn_pkg::DIV_N-1:0]  o_quot
);
    import rrn_pkg::*;

    logic [DIV_N-1:0]     r_quo;
    logic [DIV_D-1:0]     r_rem;
    logic [DIV_D-1:0]     r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;

    logic [DIV_D:0] shifted;
    logic [DIV_D:0] diff;
    logic           ge;

    // The dividend shifts out of the top of r_quo while quotient bits enter at the bottom.
    assign shifted = {r_rem, r_quo[DIV_N-1]};
    assign ge      = shifted >= {1'b0, r_dvs};
    assign diff    = shifted - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DIV_N - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_N-2:0], ge};
            r_rem <= ge ? diff[DIV_D-1:0] : shifted[DIV_D-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;

endmodule

@@ rtl/core/rrn_sqrt.sv @@
// Iterative integer square root, one root bit per cycle.
module rrn_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rrn_pkg::RAD_W-1:0]  i_radicand,
    output logic                       o_busy,
    output logic [rrn_pkg::ROOT_W-1:0] o_root
);
    import rrn_pkg::*;

    localparam int REM_W = ROOT_W + 1;

    logic [RAD_W-1:0]      r_rad;
    logic [REM_W-1:0]      r_rem;
    logic [ROOT_W-1:0]     r_root;
    logic [SQRT_CNT_W-1:0] r_cnt;
    logic                  r_busy;

    logic [REM_W+1:0] shifted;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             ge;

    // Classic digit-by-digit method: bring down two radicand bits, try root*4+1.
    assign shifted = {r_rem, r_rad[RAD_W-1:RAD_W-2]};
    assign trial   = (REM_W + 2)'({r_root, 2'b01});
    assign ge      = shifted >= trial;
    assign diff    = shifted - trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= SQRT_CNT_W'(ROOT_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

@@ tb/rms_row_normalizer_checker.sv @@
`timescale 1ns / 1ps
// Checker for the RMS row normalizer: predicts every output transaction and compares.
module rms_row_normalizer_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  rrn_pkg::t_in_item         i_in_item,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  rrn_pkg::t_out_item        i_out_item,
    input  logic                      i_cfg_we,
    input  logic [rrn_pkg::EPS_W-1:0] i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);

    localparam int ROW_CLOSE = rrn_pkg::ROW_LEN_DEF;

    logic signed [15:0]          row_x [rrn_pkg::STORE_DEPTH];
    logic signed [15:0]          row_w [rrn_pkg::STORE_DEPTH];
    logic [rrn_pkg::SUM_W-1:0]   square_sum;
    int                          row_count;
    logic [rrn_pkg::EPS_W-1:0]   epsilon;
    rrn_pkg::t_out_item          expected_q [$];
    rrn_pkg::t_out_item          want;
    int                          fails;

    assign o_fail_count = fails;

    function automatic longint floor_sqrt(longint v);
        longint lo;
        longint hi;
        longint mid;
        lo = 0;
        hi = longint'(1) << 20;
        while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (mid * mid <= v) begin
                lo = mid;
            end else begin
                hi = mid;
            end
        end
        return lo;
    endfunction

    // Quotient is truncated toward zero, then clamped to the signed 16-bit range.
    function automatic rrn_pkg::t_out_item scale_element(logic signed [15:0] x,
                                                         logic signed [15:0] w,
                                                         longint rms);
        longint             prod;
        longint             mag;
        longint             q;
        rrn_pkg::t_out_item r;
        prod        = longint'(x) * longint'(w);
        mag         = (prod < 0) ? -prod : prod;
        q           = mag / rms;
        r.saturated = 1'b0;
        r.row_last  = 1'b0;
        if (prod < 0) begin
            if (q > 32768) begin
                q           = 32768;
                r.saturated = 1'b1;
            end
            r.y_value = 16'(-q);
        end else begin
            if (q > 32767) begin
                q           = 32767;
                r.saturated = 1'b1;
            end
            r.y_value = 16'(q);
        end
        return r;
    endfunction

    function automatic void accept_element(rrn_pkg::t_in_item it);
        longint             ax;
        longint             rms;
        rrn_pkg::t_out_item r;
        row_x[row_count] = it.x_value;
        row_w[row_count] = it.weight_value;
        ax = longint'(it.x_value);
        if (ax < 0) begin
            ax = -ax;
        end
        square_sum = square_sum + rrn_pkg::SUM_W'(ax * ax);
        row_count++;
        if (it.row_end || row_count >= ROW_CLOSE || row_count >= rrn_pkg::STORE_DEPTH) begin
            rms = floor_sqrt(longint'(square_sum / row_count) + longint'(epsilon));
            if (rms == 0) begin
                rms = 1;
            end
            for (int k = 0; k < row_count; k++) begin
                r          = scale_element(row_x[k], row_w[k], rms);
                r.row_last = (k == row_count - 1);
                expected_q = {expected_q, r};
            end
            square_sum = '0;
            row_count  = 0;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            square_sum = '0;
            row_count  = 0;
            epsilon    = rrn_pkg::EPS_RESET;
            fails      = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                epsilon = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall) begin
                accept_element(i_in_item);
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected output transaction: y_value %0d", i_out_item.y_value);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_out_item.y_value !== want.y_value) begin
                        $error("y_value mismatch: expected %0d, actual %0d",
                               want.y_value, i_out_item.y_value);
                        fails++;
                    end
                    if (i_out_item.saturated !== want.saturated) begin
                        $error("saturated mismatch: expected %0b, actual %0b",
                               want.saturated, i_out_item.saturated);
                        fails++;
                    end
                    if (i_out_item.row_last !== want.row_last) begin
                        $error("row_last mismatch: expected %0b, actual %0b",
                               want.row_last, i_out_item.row_last);
                        fails++;
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

@@ tb/rms_row_normalizer_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the RMS row normalizer: clock, reset, stimulus and verdict.
module rms_row_normalizer_tb;

    localparam int  CYCLE_LIMIT  = 500000;
    localparam int  PHASE_ITEMS  = 80;
    localparam int  HOLD_CYCLES  = 600;
    localparam int  SETTLE       = 12;

    logic                      i_clk      = 1'b0;
    logic                      i_rst_n    = 1'b0;
    logic                      i_valid    = 1'b0;
    logic                      o_stall;
    rrn_pkg::t_in_item         i_in       = '0;
    logic                      o_valid;
    logic                      i_stall    = 1'b0;
    rrn_pkg::t_out_item        o_out;
    logic                      i_cfg_we   = 1'b0;
    logic [rrn_pkg::EPS_W-1:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int cycles     = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    bit hold_go    = 1'b0;
    bit calm       = 1'b0;

    rms_row_normalizer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    rms_row_normalizer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_item    (i_in),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_item   (o_out),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off so the block backs up.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (hold_go && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !calm && ($urandom_range(0, 99) < 14);
            end
        end
    end

    function automatic logic [15:0] pick_q412();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 16'($urandom);
            5, 6:          return 16'($signed($urandom_range(0, 8192)) - 4096);
            7:             return 16'($signed($urandom_range(0, 512)) - 256);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    function automatic int pick_row_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 6);
        end else if (r < 92) begin
            return $urandom_range(7, 30);
        end
        return $urandom_range(60, 64);
    endfunction

    task automatic send_item(logic [15:0] x, logic [15:0] w, logic last);
        while (!calm && $urandom_range(0, 99) < 14) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_in.x_value      <= x;
        i_in.weight_value <= w;
        i_in.row_end      <= last;
        do begin
            @(posedge i_clk);
        end while (o_stall);
    endtask

    // A row of 64 closes on its count alone, so its end flag may be either value.
    task automatic send_random_row(int len, logic end_on_full);
        for (int i = 0; i < len; i++) begin
            send_item(pick_q412(), pick_q412(),
                      (i == len - 1) ? ((len == rrn_pkg::STORE_DEPTH) ? end_on_full : 1'b1)
                                     : 1'b0);
        end
    endtask

    // The first edge lets the checker take in the last accepted transaction.
    task automatic wait_idle();
        @(posedge i_clk);
        wait (pending == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_epsilon(logic [rrn_pkg::EPS_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        int sent;
        int len;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows at the reset epsilon.
        // Single extreme element: the quotient overflows positive and clamps.
        send_item(16'h8000, 16'h8000, 1'b1);
        // Quotient of exactly -32768 is representable and must not be flagged.
        send_item(16'd4096, 16'h8000, 1'b0);
        send_item(16'd4096, 16'h0000, 1'b1);
        // Clamping in both directions within one row.
        send_item(16'h7FFF, 16'h7FFF, 1'b0);
        send_item(16'h7FFF, 16'h8000, 1'b0);
        send_item(16'h0000, 16'd5, 1'b0);
        send_item(16'h0000, -16'sd5, 1'b1);
        // All-zero row: the root comes from epsilon alone.
        send_item(16'h0000, 16'h0000, 1'b1);
        send_item(16'hFFFF, 16'h7FFF, 1'b0);
        send_item(16'h0001, 16'hFFFF, 1'b0);
        send_item(16'd12288, -16'sd4096, 1'b0);
        send_item(-16'sd20000, 16'd1234, 1'b1);
        send_item(16'h7FFF, 16'h8000, 1'b0);
        send_item(16'h8000, 16'h7FFF, 1'b1);
        i_valid <= 1'b0;
        wait_idle();

        for (int phase = 1; phase <= 5; phase++) begin
            case (phase)
                1:       write_epsilon(32'd1);
                2:       write_epsilon(32'hFFFF_FFFF);
                3:       write_epsilon($urandom_range(1, 32'h0400_0000));
                4:       write_epsilon($urandom_range(1, 32'hFFFF_FFFF));
                default: write_epsilon(rrn_pkg::EPS_RESET);
            endcase
            calm <= (phase == 3);
            sent = 0;
            if (phase == 2) begin
                hold_go <= 1'b1;
                send_random_row(rrn_pkg::STORE_DEPTH, 1'b0);
                sent = rrn_pkg::STORE_DEPTH;
            end else if (phase == 4) begin
                send_random_row(rrn_pkg::STORE_DEPTH, 1'b1);
                sent = rrn_pkg::STORE_DEPTH;
            end
            while (sent < PHASE_ITEMS) begin
                len = pick_row_len();
                send_random_row(len, $urandom_range(0, 1));
                sent += len;
            end
            i_valid <= 1'b0;
            wait_idle();
        end

        calm <= 1'b0;
        wait (pending == 0);
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
